// ===== hdl/lru_frame_replacement_top_defines.svh =====
// Assertion macros shared by the checker of the LRU frame replacement block.
// Depends on nothing; include once per file that asserts.
`ifndef LRU_FRAME_REPLACEMENT_TOP_DEFINES_SVH
`define LRU_FRAME_REPLACEMENT_TOP_DEFINES_SVH
// Implication checked on every rising edge, disabled during reset.
`define LFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication with the consequent in the next cycle.
`define LFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/lfr_pkg.sv =====
// Package for the LRU frame replacement block: transaction structs, codes, states.
// Depends on nothing.
package lfr_pkg;
    typedef enum logic [1:0] {
        FUNC_ACCESS = 2'd0,
        FUNC_FREE   = 2'd1,
        FUNC_VICTIM = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FREE   = 2'd1,
        ST_LIST   = 2'd2,
        ST_NOFRM  = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [3:0]  frame_num;
        logic [15:0] pinned_mask;
        logic [15:0] used_mask;
    } req_t;

    typedef struct packed {
        logic [3:0] victim_frame;
        logic [1:0] status;
        logic       was_resident;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_UNLINK,
        S_FRONT,
        S_DONE
    } state_t;
endpackage

// ===== hdl/lru_frame_replacement_top.sv =====
// LRU frame replacement top level: recency list, free stack, sequencer.
// Depends on lfr_pkg.
//
// Steps: an access goes through unlink, front and done; a free through unlink and done, or
// straight to done if the frame is already stacked; an unused code or out-of-range frame
// goes straight to done. A victim request pops the free stack frame by frame, then, once it
// is dry, scans the list from the least recent end; a frame found is unlinked and put at the
// front. Throughput: one transaction at a time, busy is high until done.
// Reset: asynchronous active low; list empty, all frames stacked 0,1,2,... No stalls.
module lru_frame_replacement_top #(
    parameter int FRAMES = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  lfr_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output lfr_pkg::rsp_t rsp
);
    import lfr_pkg::*;

    localparam int PW = $clog2(FRAMES + 1);   // pointer width, holds null
    localparam int IW = $clog2(FRAMES);       // index width
    localparam logic [PW-1:0] NIL = PW'(FRAMES);

    // Link arrays are register files read at a few chosen places per step.
    logic [PW-1:0] rnext_reg [FRAMES];
    logic [PW-1:0] rprev_reg [FRAMES];
    logic [PW-1:0] fnext_reg [FRAMES];
    logic [FRAMES-1:0] inrec_reg, onfree_reg;
    logic [PW-1:0] head_reg, tail_reg, ftop_reg;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [PW-1:0] cur_reg;          // frame being worked on
    logic [PW-1:0] cnt_reg;          // scan step count
    logic          front_reg;        // after unlink, put at front
    logic [1:0]    status_reg;
    logic          resid_reg;
    logic [3:0]    victim_reg;

    logic [IW-1:0] cur_i;
    assign cur_i = cur_reg[IW-1:0];

    // Mask bits for frames 16 and above read as zero.
    function automatic logic mbit(input logic [15:0] m, input logic [PW-1:0] f);
        logic r;
        r = 1'b0;
        if (int'(f) < 16)
            r = m[4'(f)];
        return r;
    endfunction

    // Decoded view of the incoming transaction and of the current search step.
    logic [IW-1:0] req_i;
    logic          req_ok;
    func_t         req_fn;
    logic          pop_ok;
    logic          scan_live;
    assign req_i     = IW'(req.frame_num);
    assign req_ok    = int'(req.frame_num) < FRAMES;
    assign req_fn    = func_t'(req.func);
    assign pop_ok    = !mbit(req_reg.pinned_mask, ftop_reg) &&
                       !mbit(req_reg.used_mask, ftop_reg);
    assign scan_live = (cnt_reg < PW'(FRAMES)) && (cur_reg < NIL);

    // Next state. A popped frame that is usable or an unpinned list entry leads to
    // the unlink and front steps; an empty stack switches over to the list scan.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (!req_ok && req_fn != FUNC_VICTIM)
                        state_next = S_DONE;
                    else
                    begin
                        case (req_fn)
                            FUNC_ACCESS: state_next = S_UNLINK;
                            FUNC_FREE:   state_next = onfree_reg[req_i] ? S_DONE : S_UNLINK;
                            FUNC_VICTIM: state_next = S_POP;
                            default:     state_next = S_DONE;
                        endcase
                    end
                end
            end
            S_POP:
            begin
                if (ftop_reg < NIL)
                begin
                    if (pop_ok)
                        state_next = S_UNLINK;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_live)
                begin
                    if (!mbit(req_reg.pinned_mask, cur_reg))
                        state_next = S_UNLINK;
                end
                else
                    state_next = S_DONE;
            end
            S_UNLINK: state_next = front_reg ? S_FRONT : S_DONE;
            S_FRONT:  state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        rsp.victim_frame = victim_reg;
        rsp.status       = status_reg;
        rsp.was_resident = resid_reg;
    end

    logic [PW-1:0] p_w, n_w;
    assign p_w = rprev_reg[cur_i];
    assign n_w = rnext_reg[cur_i];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            inrec_reg  <= '0;
            onfree_reg <= '1;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            ftop_reg   <= '0;
            for (int i = 0; i < FRAMES; i++)
            begin
                rnext_reg[i] <= NIL;
                rprev_reg[i] <= NIL;
                fnext_reg[i] <= PW'(i + 1);
            end
            cur_reg    <= '0;
            cnt_reg    <= '0;
            front_reg  <= 1'b0;
            status_reg <= '0;
            resid_reg  <= 1'b0;
            victim_reg <= '0;
            req_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg    <= req;
                        cur_reg    <= PW'(req.frame_num);
                        status_reg <= (req_fn == FUNC_VICTIM) ? ST_NOFRM : ST_DONE;
                        victim_reg <= '0;
                        resid_reg  <= req_ok && (req_fn inside {FUNC_ACCESS, FUNC_FREE}) &&
                                      inrec_reg[req_i];
                        front_reg  <= req_ok && (req_fn == FUNC_ACCESS);
                        cnt_reg    <= '0;
                        // A free pushes the frame unless it is already stacked.
                        if (req_ok && req_fn == FUNC_FREE && !onfree_reg[req_i])
                        begin
                            fnext_reg[req_i]  <= ftop_reg;
                            ftop_reg          <= PW'(req.frame_num);
                            onfree_reg[req_i] <= 1'b1;
                        end
                    end
                end
                S_POP:
                begin
                    // One pop per cycle.
                    if (ftop_reg < NIL)
                    begin
                        ftop_reg <= fnext_reg[ftop_reg[IW-1:0]];
                        fnext_reg[ftop_reg[IW-1:0]] <= NIL;
                        onfree_reg[ftop_reg[IW-1:0]] <= 1'b0;
                        if (pop_ok)
                        begin
                            cur_reg    <= ftop_reg;
                            victim_reg <= 4'(ftop_reg);
                            status_reg <= ST_FREE;
                            front_reg  <= 1'b1;
                        end
                    end
                    else
                        cur_reg <= tail_reg;
                end
                S_SCAN:
                begin
                    // One list entry per cycle, from the least recent end.
                    if (scan_live)
                    begin
                        if (!mbit(req_reg.pinned_mask, cur_reg))
                        begin
                            victim_reg <= 4'(cur_reg);
                            status_reg <= ST_LIST;
                            front_reg  <= 1'b1;
                        end
                        else
                        begin
                            cur_reg <= p_w;
                            cnt_reg <= cnt_reg + PW'(1);
                        end
                    end
                end
                S_UNLINK:
                begin
                    if (inrec_reg[cur_i])
                    begin
                        if (p_w < NIL) rnext_reg[p_w[IW-1:0]] <= n_w;
                        else           head_reg <= n_w;
                        if (n_w < NIL) rprev_reg[n_w[IW-1:0]] <= p_w;
                        else           tail_reg <= p_w;
                        rnext_reg[cur_i] <= NIL;
                        rprev_reg[cur_i] <= NIL;
                        inrec_reg[cur_i] <= 1'b0;
                    end
                end
                S_FRONT:
                begin
                    rprev_reg[cur_i] <= NIL;
                    rnext_reg[cur_i] <= head_reg;
                    if (head_reg < NIL) rprev_reg[head_reg[IW-1:0]] <= cur_reg;
                    else                tail_reg <= cur_reg;
                    head_reg <= cur_reg;
                    inrec_reg[cur_i] <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/lfr_checker.sv =====
// Port-level checker for the LRU frame replacement block, with its bind.
// Depends on lfr_pkg and lru_frame_replacement_top_defines.svh.
`include "lru_frame_replacement_top_defines.svh"
module lfr_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input lfr_pkg::rsp_t rsp
);
    import lfr_pkg::*;

    `LFR_ASSERT_NXT(a_start_busy, start && !busy, busy, "no busy after start")
    `LFR_ASSERT_NXT(a_done_once, done, !done && !busy, "done not single")
    `LFR_ASSERT_IMP(a_done_busy, done, busy, "done while idle")
    `LFR_ASSERT_IMP(a_vic_zero, done && (rsp.status == ST_DONE || rsp.status == ST_NOFRM),
        rsp.victim_frame == 4'd0, "victim nonzero")
    `LFR_ASSERT_IMP(a_res_vic, done && rsp.status != ST_DONE, !rsp.was_resident,
        "resident on victim")
endmodule

bind lru_frame_replacement_top lfr_checker u_lfr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
